/* hw/rtl/amgs_pkg.sv */
// Shared types and constants for the adjacency matrix graph store.
// Used by amgs_ctrl, amgs_dp, the top level and the port checker.
package amgs_pkg;

  // Default table depth, handed down from the top level
  localparam int MAX_VERTICES_DEF = 16;

  localparam int LABEL_W  = 16;
  localparam int VTOTAL_W = 5;
  localparam int ATOTAL_W = 9;

  // Arc count saturates at all ones
  localparam logic [ATOTAL_W-1:0] ARC_LIMIT = '1;

  // Request codes
  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_ARC    = 1'b1;

  // Input word
  typedef struct packed {
    logic               operation;
    logic [LABEL_W-1:0] first_label;
    logic [LABEL_W-1:0] second_label;
  } amgs_in_t;

  // Result word
  typedef struct packed {
    logic                success;
    logic [VTOTAL_W-1:0] vertex_total;
    logic [ATOTAL_W-1:0] arc_total;
  } amgs_out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DECIDE,
    ST_READ,
    ST_CHECK,
    ST_MIRROR,
    ST_RESP
  } amgs_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic vtx_commit;
    logic rd_rows;
    logic arc_commit;
    logic mirror_wr;
    logic load_out;
  } amgs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic op;
    logic hit_a;
    logic hit_b;
    logic full;
    logic dup_arc;
    logic need_mirror;
    logic out_free;
  } amgs_sts_t;

endpackage

/* hw/rtl/adjacency_matrix_graph_store_top.sv */
// Adjacency matrix graph store. Holds up to MAX_VERTICES 16-bit vertex
// labels and a square arc bit matrix kept as one row memory with a single
// write port and registered reads. One request is worked at a time: an
// insert-vertex request, or an insert-arc request with a missing label,
// passes the match and decide states and then loads its result; an
// insert-arc request whose labels both match also reads both rows and
// checks the arc, and writes the mirrored bit of an undirected graph in a
// further state, since both row writes share the one memory write port.
// The next word is taken once the controller is back in idle after the
// result loads, and the load waits while a held result is stalled. No
// clearing pass is needed after reset: a new vertex clears its own row,
// and its column is already zero in every earlier row.
module adjacency_matrix_graph_store_top #(
  parameter int MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  amgs_pkg::amgs_in_t in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output amgs_pkg::amgs_out_t out_word,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);
  import amgs_pkg::*;

  amgs_cmd_t cmd;
  amgs_sts_t sts;

  amgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  amgs_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

/* hw/rtl/amgs_ctrl.sv */
// Request sequencer for the adjacency matrix graph store.
// Depends on amgs_pkg; drives amgs_dp through the command struct.
module amgs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  amgs_pkg::amgs_sts_t sts,
  output amgs_pkg::amgs_cmd_t cmd
);
  import amgs_pkg::*;

  amgs_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.op == OP_VERTEX) begin
          cmd.vtx_commit = !sts.full && !sts.hit_a;
          state_nxt      = ST_RESP;
        end else if (sts.hit_a && sts.hit_b) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_READ: begin
        cmd.rd_rows = 1'b1;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.dup_arc) begin
          cmd.arc_commit = 1'b1;
          state_nxt      = sts.need_mirror ? ST_MIRROR : ST_RESP;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_MIRROR: begin
        cmd.mirror_wr = 1'b1;
        state_nxt     = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/amgs_dp.sv */
// Datapath of the adjacency matrix graph store: label table, arc row
// memory, counters and result register. Depends on amgs_pkg.
module amgs_dp #(
  parameter int MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  amgs_pkg::amgs_in_t  in_word,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  amgs_pkg::amgs_cmd_t cmd,
  output amgs_pkg::amgs_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output amgs_pkg::amgs_out_t out_word
);
  import amgs_pkg::*;

  localparam int IW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VCW = $clog2(MAX_VERTICES + 1);

  // Configuration
  logic mode_r;

  // Request registers
  logic               op_r;
  logic [LABEL_W-1:0] lab_a_r, lab_b_r;

  // Label table, compared in parallel
  logic [LABEL_W-1:0] label_r [MAX_VERTICES];

  // Match vectors and encoded indices
  logic [MAX_VERTICES-1:0] vec_a_r, vec_b_r;
  logic [IW-1:0]           idx_a_r, idx_b_r;
  logic [IW-1:0]           idx_a_nxt, idx_b_nxt;
  logic [MAX_VERTICES-1:0] vec_a_nxt, vec_b_nxt;

  // Arc row memory and read registers
  logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_a_r, row_b_r;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic [MAX_VERTICES-1:0] wr_data;
  logic [MAX_VERTICES-1:0] bit_a, bit_b;

  // Counters and result
  logic [VCW-1:0]      vcnt_r;
  logic [ATOTAL_W-1:0] acnt_r;
  logic                ok_r;
  logic                out_valid_r;
  amgs_out_t           out_word_r;
  logic [31:0]         vcnt_ext;
  logic                out_free;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_word.operation;
      lab_a_r <= in_word.first_label;
      lab_b_r <= in_word.second_label;
    end
  end

  // Match both labels against the stored entries
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      vec_a_nxt[i] = (label_r[i] == lab_a_r) && (VCW'(i) < vcnt_r);
      vec_b_nxt[i] = (label_r[i] == lab_b_r) && (VCW'(i) < vcnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      vec_a_r <= vec_a_nxt;
      vec_b_r <= vec_b_nxt;
    end
  end

  // Encode the one-hot match vectors; stored labels are unique
  always_comb begin
    idx_a_nxt = '0;
    idx_b_nxt = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (vec_a_r[i]) idx_a_nxt = idx_a_nxt | IW'(i);
      if (vec_b_r[i]) idx_b_nxt = idx_b_nxt | IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    idx_a_r <= idx_a_nxt;
    idx_b_r <= idx_b_nxt;
  end

  // Append a label
  always_ff @(posedge clk) begin
    if (cmd.vtx_commit) begin
      label_r[vcnt_r[IW-1:0]] <= lab_a_r;
    end
  end

  // Row memory write port: clear a new row, set the arc or its mirror
  assign bit_a = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << idx_a_r;
  assign bit_b = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << idx_b_r;

  always_comb begin
    wr_en = cmd.vtx_commit | cmd.arc_commit | cmd.mirror_wr;
    priority if (cmd.vtx_commit) begin
      wr_addr = vcnt_r[IW-1:0];
      wr_data = '0;
    end else if (cmd.arc_commit) begin
      wr_addr = idx_a_r;
      wr_data = row_a_r | bit_b;
    end else begin
      wr_addr = idx_b_r;
      wr_data = row_b_r | bit_a;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
  end

  // Read tail and head rows
  always_ff @(posedge clk) begin
    if (cmd.rd_rows) begin
      row_a_r <= row_mem[idx_a_r];
      row_b_r <= row_mem[idx_b_r];
    end
  end

  // Advance the counters and the success flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
      acnt_r <= '0;
    end else begin
      if (cmd.vtx_commit) begin
        vcnt_r <= vcnt_r + VCW'(1);
      end
      if (cmd.arc_commit && acnt_r != ARC_LIMIT) begin
        acnt_r <= acnt_r + ATOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ok_r <= 1'b0;
    end else if (cmd.vtx_commit || cmd.arc_commit) begin
      ok_r <= 1'b1;
    end
  end

  // Result register; drop valid once the word is taken
  assign out_free = !out_valid_r || !out_stall;
  assign vcnt_ext = 32'(vcnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_word_r.success      <= ok_r;
      out_word_r.vertex_total <= vcnt_ext[VTOTAL_W-1:0];
      out_word_r.arc_total    <= acnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Status to the controller
  always_comb begin
    sts.op          = op_r;
    sts.hit_a       = |vec_a_r;
    sts.hit_b       = |vec_b_r;
    sts.full        = (vcnt_r == VCW'(MAX_VERTICES));
    sts.dup_arc     = row_a_r[idx_b_r];
    sts.need_mirror = mode_r && (idx_a_r != idx_b_r);
    sts.out_free    = out_free;
  end

endmodule

/* hw/rtl/amgs_chk.sv */
// Port checker for the adjacency matrix graph store, bound to the top level.
// Depends on amgs_pkg for the word types.
module amgs_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input amgs_pkg::amgs_out_t out_word,
  input logic                out_valid,
  input logic                out_stall
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed under stall");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One request in flight: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

endmodule

bind adjacency_matrix_graph_store_top amgs_chk u_amgs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_word  (out_word),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
